### rtl/tdpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tdpt_pkg;

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_EVAL = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    // which divisor the shared divider is working on
    typedef enum logic [1:0] {
        SEL_THREE = 2'd0,   // screen for multiples of three
        SEL_LO    = 2'd1,   // candidate 6k-1
        SEL_HI    = 2'd2    // candidate 6k+1
    } t_div_sel;

    localparam logic [7:0] C_THREE      = 8'd3;
    localparam logic [7:0] C_FIRST_CAND = 8'd5;
    localparam logic [7:0] C_PAIR_GAP   = 8'd2;
    localparam logic [7:0] C_CAND_STEP  = 8'd6;

endpackage

`default_nettype wire

### rtl/trial_division_prime_test.sv
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | handshake           | payload
// --------+-----------+---------------------+------------------------------
// input   | in        | i_valid / o_stall   | i_value [63:0]
// result  | out       | o_valid / i_stall   | o_is_prime
//
// Flow: values below 2, 2, 3 and even values go from accept straight to the result.
//   Others run D divisions on the shared divider (ST_DIV, then ST_EVAL per division):
//   one by 3, then two per 6k-1 / 6k+1 pair up to sqrt(n) (about 2 + sqrt(n)/3).
// Reset: synchronous, active low; clears the sequencer and the output valid.
// Stalls: o_stall is high while an item is in work; a finished result waits for
//   the output register, which may still hold the previous result.

module trial_division_prime_test
    import tdpt_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [63:0] i_value,
    output logic             o_stall,
    output logic             o_valid,
    output logic             o_is_prime,
    input  wire logic        i_stall
);

    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(W);

    t_state         r_state, n_state;
    t_div_sel       r_sel, n_sel;
    logic [W-1:0]   r_n, n_n;        // value under test
    logic [W-1:0]   r_d, n_d;        // current 6k-1 candidate
    logic [W-1:0]   r_div, n_div;    // divisor in the divider
    logic [W-1:0]   r_rem, n_rem;    // partial remainder
    logic [W-1:0]   r_quo, n_quo;    // dividend shifting out, quotient in
    logic [CW-1:0]  r_cnt, n_cnt;    // remaining divide steps
    logic           r_res, n_res;    // pending verdict
    logic           r_out_valid, n_out_valid;
    logic           r_out_prime, n_out_prime;

    logic [W-1:0]   w_val;
    logic           w_in_acc;
    logic           w_out_free;
    logic [W:0]     w_trial;
    logic [W+1:0]   w_diff;
    logic           w_ge;

    assign w_val      = i_value[W-1:0];
    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;

    // shared divider step: shift in next dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_quo[W-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_div};
    assign w_ge    = !w_diff[W+1];

    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        n_n         = r_n;
        n_d         = r_d;
        n_div       = r_div;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_stall;
        n_out_prime = r_out_prime;

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_n = w_val;
                    if (w_val < W'(2)) begin
                        n_res   = 1'b0;
                        n_state = ST_DONE;
                    end else if (w_val == W'(2) || w_val == W'(C_THREE)) begin
                        n_res   = 1'b1;
                        n_state = ST_DONE;
                    end else if (!w_val[0]) begin
                        n_res   = 1'b0;
                        n_state = ST_DONE;
                    end else begin
                        n_sel   = SEL_THREE;
                        n_div   = W'(C_THREE);
                        n_rem   = '0;
                        n_quo   = w_val;
                        n_cnt   = CW'(W - 1);
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                n_rem = w_ge ? w_diff[W-1:0] : w_trial[W-1:0];
                n_quo = {r_quo[W-2:0], w_ge};
                if (r_cnt == '0) begin
                    n_state = ST_EVAL;
                end else begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            ST_EVAL: begin
                // r_quo holds n / divisor, r_rem holds n % divisor
                n_rem   = '0;
                n_quo   = r_n;
                n_cnt   = CW'(W - 1);
                n_state = ST_DIV;
                case (r_sel)
                    SEL_THREE: begin
                        if (r_rem == '0) begin
                            n_res   = 1'b0;
                            n_state = ST_DONE;
                        end else begin
                            n_d   = W'(C_FIRST_CAND);
                            n_div = W'(C_FIRST_CAND);
                            n_sel = SEL_LO;
                        end
                    end
                    SEL_LO: begin
                        if (r_d > r_quo) begin
                            // d*d > n: no factor left to find
                            n_res   = 1'b1;
                            n_state = ST_DONE;
                        end else if (r_rem == '0) begin
                            n_res   = 1'b0;
                            n_state = ST_DONE;
                        end else begin
                            n_div = r_d + W'(C_PAIR_GAP);
                            n_sel = SEL_HI;
                        end
                    end
                    SEL_HI: begin
                        if (r_rem == '0) begin
                            n_res   = 1'b0;
                            n_state = ST_DONE;
                        end else begin
                            n_d   = r_d + W'(C_CAND_STEP);
                            n_div = r_d + W'(C_CAND_STEP);
                            n_sel = SEL_LO;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_prime = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel       <= n_sel;
        r_n         <= n_n;
        r_d         <= n_d;
        r_div       <= n_div;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_cnt       <= n_cnt;
        r_res       <= n_res;
        r_out_prime <= n_out_prime;
    end

    assign o_stall    = (r_state != ST_IDLE);
    assign o_valid    = r_out_valid;
    assign o_is_prime = r_out_prime;

endmodule

`default_nettype wire

### rtl/tdpt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tdpt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic [63:0] i_value,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        o_is_prime,
    input wire logic        i_stall
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_is_prime)))
        else $error("result changed while stalled");

    // the block is busy right after taking an item
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("not busy after item accepted");

    // a new result only appears at the end of a busy period
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without work");

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // an accepted item is well defined
    a_value_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |-> !$isunknown(i_value))
        else $error("unknown value accepted");

endmodule

bind trial_division_prime_test tdpt_checker u_tdpt_checker (.*);

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps

// Bench for trial_division_prime_test.
// One item in (a 64-bit value), one flag out. Every accepted item queues its
// expected flag, and every accepted result is checked against the oldest one.
//
// Run time is the main concern: the block divides up to sqrt(n), so a large
// prime would be far too slow to simulate. Large values are therefore always
// built with a small factor, which the block and the predictor both reject
// after a few candidates. Primes and hard composites (two odd factors near
// the square root) stay below 2^20.

module tb;
    localparam int VW = 64;
    localparam logic [63:0] WIDTH_MASK = {64{1'b1}} >> (64 - VW);
    localparam int N_DIRECTED = 24;
    localparam int N_RANDOM = 76;
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE_CYCLES = 200;

    // directed row: value, whether the flag is typed in, and the flag
    typedef struct packed {
        logic [63:0] value;
        bit          known;
        bit          flag;
    } t_row;

    // one outstanding verdict: the value it belongs to and the flag it needs
    typedef struct {
        logic [63:0] value;
        bit          flag;
    } t_verdict;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [63:0] in_value = '0;
    logic        out_stall = 1'b0;
    logic        dut_stall;
    logic        out_valid;
    logic        out_is_prime;

    t_verdict pending_verdicts[$];

    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned items_sent = 0;
    int unsigned large_items = 0;
    int unsigned results_checked = 0;
    int unsigned primes_seen = 0;
    int unsigned mismatches = 0;

    // Directed rows: zero and one, two and three, the first candidates, squares
    // of candidates (divisor exactly at the bound), products of a 6k-1 / 6k+1
    // pair, the biggest primes that still run fast, and the top of the range.
    t_row directed_rows [0:N_DIRECTED-1] = '{
        '{64'd0,                    1'b1, 1'b0},
        '{64'd1,                    1'b1, 1'b0},
        '{64'd2,                    1'b1, 1'b1},
        '{64'd3,                    1'b1, 1'b1},
        '{64'd4,                    1'b1, 1'b0},
        '{64'd5,                    1'b0, 1'b0},
        '{64'd7,                    1'b0, 1'b0},
        '{64'd9,                    1'b1, 1'b0},
        '{64'd25,                   1'b0, 1'b0},
        '{64'd35,                   1'b0, 1'b0},
        '{64'd49,                   1'b0, 1'b0},
        '{64'd121,                  1'b0, 1'b0},
        '{64'd143,                  1'b0, 1'b0},
        '{64'd169,                  1'b0, 1'b0},
        '{64'd4087,                 1'b0, 1'b0},
        '{64'd65521,                1'b0, 1'b0},
        '{64'd999983,               1'b0, 1'b0},
        '{64'h8000_0000_0000_0000,  1'b1, 1'b0},
        '{64'hFFFF_FFFF_FFFF_FFFE,  1'b1, 1'b0},
        '{64'hFFFF_FFFF_FFFF_FFFF,  1'b1, 1'b0},   // 3 divides 2^64-1
        '{64'hFFFF_FFFF_FFFF_FFF5,  1'b0, 1'b0},   // multiple of 5
        '{64'hFFFF_FFFF_FFFF_FFF7,  1'b0, 1'b0},   // multiple of 7
        '{64'hAAAA_AAAA_AAAA_AAAA,  1'b1, 1'b0},
        '{64'h5555_5555_5555_5555,  1'b0, 1'b0}    // multiple of 5
    };

    trial_division_prime_test #(
        .VALUE_WIDTH(VW)
    ) dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_valid   (in_valid),
        .i_value   (in_value),
        .o_stall   (dut_stall),
        .o_valid   (out_valid),
        .o_is_prime(out_is_prime),
        .i_stall   (out_stall)
    );

    always #10 clk = ~clk;

    // Primality by 6k-1 / 6k+1 trial division. The bound is d <= n/d, so it
    // never wraps, even at the top of the range.
    function automatic bit prime_verdict(input logic [63:0] raw);
        logic [63:0] n;
        logic [63:0] d;
        n = raw & WIDTH_MASK;
        if (n < 64'd2) return 1'b0;
        if (n == 64'd2 || n == 64'd3) return 1'b1;
        if (n % 64'd2 == 0 || n % 64'd3 == 0) return 1'b0;
        for (d = 64'd5; d <= n / d; d += 64'd6) begin
            if (n % d == 0 || n % (d + 64'd2) == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Random value mix: mostly small numbers (plenty of primes), some up to
    // 16 bits, products of two odd factors so the search runs to the bound,
    // and full-width values that carry a small prime factor.
    function automatic logic [63:0] draw_value();
        int unsigned sel;
        logic [63:0] r;
        logic [63:0] p;
        logic [63:0] a;
        logic [63:0] b;
        sel = $urandom_range(99);
        if (sel < 55) begin
            r = 64'($urandom_range(4095));
        end else if (sel < 70) begin
            r = 64'($urandom_range(65535));
        end else if (sel < 82) begin
            a = 64'($urandom_range(125, 2)) * 2 + 1;
            b = 64'($urandom_range(125, 2)) * 2 + 1;
            r = a * b;
        end else begin
            r = {$urandom, $urandom};
            case ($urandom_range(7))
                0: p = 64'd2;
                1: p = 64'd3;
                2: p = 64'd5;
                3: p = 64'd7;
                4: p = 64'd11;
                5: p = 64'd13;
                6: p = 64'd29;
                default: p = 64'd31;
            endcase
            r = r - (r % p);
        end
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance,
    // with valid still high so back-to-back items need no extra assignment.
    task automatic send_value(input logic [63:0] v, input bit known, input bit flag);
        t_verdict entry;
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_value <= v;
        do @(posedge clk); while (dut_stall);
        entry.value = v;
        entry.flag = known ? flag : prime_verdict(v);
        pending_verdicts = {pending_verdicts, entry};
        items_sent++;
        if (v[63:32] != 0) large_items++;
        @(negedge clk);
    endtask

    // receiver stall, redrawn every cycle
    always @(negedge clk) begin
        out_stall <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);
    end

    // result checker
    always @(posedge clk) begin
        t_verdict head;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("tb: result %0b with no item outstanding", out_is_prime);
            end else begin
                head = pending_verdicts.pop_front();
                results_checked++;
                if (out_is_prime) primes_seen++;
                if (out_is_prime !== head.flag) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("tb: value %0d: expected is_prime %0b, got %b",
                                 head.value, head.flag, out_is_prime);
                end
            end
        end
    end

    // hard limit, far beyond the slowest legal run
    initial begin
        #200_000_000;
        $display("tb: errors");
        $finish;
    end

    initial begin
        int unsigned phase;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table, no idling on either side
        for (int i = 0; i < N_DIRECTED; i++)
            send_value(directed_rows[i].value, directed_rows[i].known, directed_rows[i].flag);

        // random items in four idling phases: none, sender, receiver, both
        for (int i = 0; i < N_RANDOM; i++) begin
            phase = i / (N_RANDOM / 4);
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 54; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 54; end
                default: begin sender_idle_pct = 20; receiver_stall_pct = 20; end
            endcase
            send_value(draw_value(), 1'b0, 1'b0);
        end
        in_valid <= 1'b0;

        // drain, then watch a little longer for stray results
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("tb: %0d items sent (%0d above 32 bits), %0d results checked",
                 items_sent, large_items, results_checked);
        $display("tb: %0d primes reported, %0d mismatches", primes_seen, mismatches);
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
